FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the odometry core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked at every clock edge outside reset.
`define ASO_ASSERT(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Same-cycle implication.
`define ASO_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/aso_pkg.sv
// Shared constants, types and fixed-point helpers of the odometry core.
package aso_pkg;

    localparam int WINDOW   = 10;
    localparam int WIN_IW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W   = $clog2(WINDOW + 1);
    localparam int CORDIC_N = 30;
    localparam int CI_W     = $clog2(CORDIC_N + 1);
    localparam int CW       = 34;
    localparam int DW       = CW + 3;
    localparam int CFG_IW   = 2;

    localparam logic [CFG_IW-1:0] REG_WHEEL_SEP = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] REG_WHEEL_RAD = CFG_IW'(1);

    localparam logic [1:0] OP_ENC  = 2'd0;
    localparam logic [1:0] OP_VEL  = 2'd1;
    localparam logic [1:0] OP_TREF = 2'd2;

    localparam logic [63:0] INV_2PI_Q64     = 64'h28BE60DB9391054A;
    localparam logic [63:0] TWO_OVER_PI_Q32 = 64'd2734261102;
    localparam logic signed [CW-1:0] CORDIC_K = CW'(652032874);
    localparam logic signed [31:0] STEER_MAX = 32'sd1686629713;
    localparam logic [63:0] ANG_EPS    = 64'd4295;
    localparam logic [47:0] MIN_DT_US  = 48'd100;
    localparam logic [63:0] US_PER_S   = 64'd1000000;
    localparam logic signed [63:0] SAMPLE_MAX = 64'sd576460752303423487;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFFFFFFFFFFFFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000000000000000;
    localparam logic [31:0] SEP_RESET = 32'd65536;
    localparam logic [31:0] RAD_RESET = 32'd6554;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    function automatic logic [63:0] f_mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] f_apply(input logic [63:0] m, input logic neg);
        if (neg) begin
            return m[63] ? S64_MIN : -$signed(m);
        end
        return m[63] ? S64_MAX : $signed(m);
    endfunction

    function automatic logic signed [63:0] f_sat_add(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) return S64_MAX;
        if (a[63] && b[63] && !s[63]) return S64_MIN;
        return s;
    endfunction

    function automatic logic signed [63:0] f_sat_sub(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a - b;
        if (!a[63] && b[63] && s[63]) return S64_MAX;
        if (a[63] && !b[63] && !s[63]) return S64_MIN;
        return s;
    endfunction

    // product {hi,lo} shifted right by sh, saturated, then signed
    function automatic logic signed [63:0] f_mul_post(input logic [127:0] p, input int sh,
                                                       input logic neg);
        logic [63:0] res;
        res = ((p[127:64] >> sh) != 64'd0) ? '1 : 64'(p >> sh);
        return f_apply(res, neg);
    endfunction

    function automatic logic signed [63:0] f_clamp(input logic signed [63:0] v);
        if (v > SAMPLE_MAX) return SAMPLE_MAX;
        if (v < -SAMPLE_MAX) return -SAMPLE_MAX;
        return v;
    endfunction

    function automatic logic [31:0] f_atan(input logic [CI_W-1:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/core/aso_mul.sv
// Bit-serial 64x64 unsigned shift-add multiplier, one multiplier bit per cycle.
module aso_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [63:0]          i_a,
    input  logic [63:0]          i_b,
    output logic [127:0]         o_prod,
    output aso_pkg::t_unit_stat  o_stat
);
    import aso_pkg::*;

    logic [63:0]  r_a;
    logic [127:0] r_p;
    logic [5:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [64:0]  w_sum;

    assign w_sum = {1'b0, r_p[127:64]} + (r_p[0] ? {1'b0, r_a} : 65'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {64'd0, i_b};
        end else if (r_busy) begin
            r_p <= {w_sum, r_p[63:1]};
        end
    end

    assign o_prod = r_p;
    assign o_stat = '{busy: r_busy, done: r_done};

endmodule

FILE: rtl/core/aso_div.sv
// Bit-serial restoring divider, 128 by 64 bits, quotient saturated to 64 bits.
module aso_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [63:0]          i_hi,
    input  logic [63:0]          i_lo,
    input  logic [63:0]          i_d,
    output logic [63:0]          o_quot,
    output aso_pkg::t_unit_stat  o_stat
);
    import aso_pkg::*;

    logic [63:0] r_r;
    logic [63:0] r_l;
    logic [63:0] r_d;
    logic [63:0] r_q;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [63:0] w_sh;
    logic        w_ge;
    logic        w_ovf;

    assign w_sh  = {r_r[62:0], r_l[63]};
    assign w_ge  = r_r[63] || (w_sh >= r_d);
    assign w_ovf = i_hi >= i_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !w_ovf;
                r_done <= w_ovf;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_r <= i_hi;
            r_l <= i_lo;
            r_d <= i_d;
            r_q <= w_ovf ? '1 : 64'd0;
        end else if (r_busy) begin
            r_r <= w_ge ? (w_sh - r_d) : w_sh;
            r_l <= {r_l[62:0], 1'b0};
            r_q <= {r_q[62:0], w_ge};
        end
    end

    assign o_quot = r_q;
    assign o_stat = '{busy: r_busy, done: r_done};

endmodule

FILE: rtl/core/aso_cordic.sv
// Iterative rotation CORDIC: 32-bit phase in, Q4.30 sine and cosine out.
module aso_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [31:0]                       i_phase,
    output logic signed [aso_pkg::CW-1:0]     o_sin,
    output logic signed [aso_pkg::CW-1:0]     o_cos,
    output aso_pkg::t_unit_stat               o_stat
);
    import aso_pkg::*;

    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [32:0]   r_z;
    logic [1:0]           r_q;
    logic [CI_W-1:0]      r_i;
    logic                 r_busy;
    logic                 r_done;
    logic signed [CW-1:0] r_sin;
    logic signed [CW-1:0] r_cos;

    logic [1:0]           w_q;
    logic [31:0]          w_rr;
    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    logic signed [32:0]   w_at;
    logic                 w_last;

    assign w_q    = 2'((i_phase + 32'h2000_0000) >> 30);
    assign w_rr   = i_phase - {w_q, 30'd0};
    assign w_dx   = r_y >>> r_i;
    assign w_dy   = r_x >>> r_i;
    assign w_at   = $signed({1'b0, f_atan(r_i)});
    assign w_last = r_i == CI_W'(CORDIC_N);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + CI_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= CORDIC_K;
            r_y <= '0;
            r_z <= 33'(signed'(w_rr));
            r_q <= w_q;
        end else if (r_busy) begin
            if (w_last) begin
                unique case (r_q)
                    2'd0: begin r_cos <= r_x;  r_sin <= r_y;  end
                    2'd1: begin r_cos <= -r_y; r_sin <= r_x;  end
                    2'd2: begin r_cos <= -r_x; r_sin <= -r_y; end
                    2'd3: begin r_cos <= r_y;  r_sin <= -r_x; end
                    default: begin r_cos <= r_x; r_sin <= r_y; end
                endcase
            end else if (!r_z[32]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_sin  = r_sin;
    assign o_cos  = r_cos;
    assign o_stat = '{busy: r_busy, done: r_done};

endmodule

FILE: rtl/core/articulated_steering_odometry_core.sv
// Articulated steering odometry: sequencer, pose and speed state, shared serial units.
//
// Input stream (s_t*): one transaction per update. tuser carries the op code:
// encoder update, open-loop velocity update or time reference set. Output
// stream (m_t*): exactly one transaction per input with the pose, the speed
// estimate and a flag in tuser telling whether the speeds were refreshed.
// Config channel (i_cfg_*): index 0 wheel separation, 1 wheel radius, Q16.16;
// write only while the core is idle. It is always ready.
// One item is worked at a time. A time reference set needs no arithmetic
// unit; open-loop and encoder updates take longer for a large angular step,
// and an encoder update longer still when the speed window refreshes. Their
// time is set by the bit-serial multiplier and divider and the CORDIC, used
// in sequence.
// A finished result sits in the output register; the next item is accepted
// while it waits, and its result is held back until the receiver takes the
// previous one. Synchronous reset clears pose, time reference, speeds and
// window count, and restores the register defaults.
`include "assert_macros.svh"

module articulated_steering_odometry_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // wheel_angle[63:0], steer_angle[95:64], lin_vel[159:96],
    // ang_vel[223:160], time_us[271:224]
    input  logic [271:0]                s_tdata,
    // op[1:0]
    input  logic [1:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // pos_x[63:0], pos_y[127:64], heading_out[191:128],
    // lin_speed[255:192], ang_speed[319:256]
    output logic [319:0]                m_tdata,
    // speed_updated[0]
    output logic                        m_tuser,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [aso_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [31:0]                 i_cfg_data
);
    import aso_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP,
        E_STEER, E_TRIG, E_TAN, E_DIST, E_ANGM, E_ANGD,
        V_LM, V_LD, V_AM, V_AD,
        I_BEG, I_PH0, I_CS0, IS_X, IS_Y, IL_R, IL_PH1, IL_CS1, IL_X, IL_Y,
        P_CHK, P_LM, P_LD, P_AM, P_AD, P_WIN, P_LMEAN, P_AMEAN,
        S_OUT
    } t_state;

    t_state r_state;

    // unit launch
    logic        r_mul_go, r_div_go, r_cor_go;
    logic [63:0] r_ma, r_mb, r_dhi, r_dlo, r_dd;
    logic [31:0] r_ph;

    logic [127:0]         w_prod;
    logic [63:0]          w_quot;
    logic signed [CW-1:0] w_sin, w_cos;
    t_unit_stat           w_mst, w_dst, w_cst;

    // item and scratch
    logic [1:0]           r_op;
    logic signed [63:0]   r_wa, r_lv, r_av;
    logic signed [31:0]   r_steer;
    logic [47:0]          r_t, r_dt, r_vm;
    logic                 r_vneg, r_sgn, r_hneg, r_small, r_flag;
    logic signed [63:0]   r_tn, r_lin, r_ang, r_r, r_ls, r_as;
    logic signed [CW-1:0] r_s0, r_c0;
    logic signed [DW-1:0] r_dc;

    // block state
    logic signed [63:0]   r_x, r_y, r_hd, r_prev, r_lsum, r_asum, r_lspd, r_aspd;
    logic [47:0]          r_tref;
    logic [WIN_IW-1:0]    r_head;
    logic [FILL_W-1:0]    r_fill;
    logic [31:0]          r_sep, r_rad;
    logic signed [63:0]   r_lwin [WINDOW];
    logic signed [63:0]   r_awin [WINDOW];

    // output register
    logic                 r_mv;
    logic [319:0]         r_mdata;
    logic                 r_muser;

    // combinational helpers
    logic signed [31:0]   w_in_steer, w_steer_cl;
    logic signed [63:0]   w_steer64, w_sin64, w_cos64, w_s0x4, w_ds, w_dc64;
    logic signed [63:0]   w_ccl, w_dist, w_lin, w_t1, w_h, w_hnew, w_post32;
    logic [63:0]          w_m;
    logic signed [48:0]   w_vdt;
    logic [47:0]          w_vm, w_tdiff;
    logic [31:0]          w_php;
    logic                 w_in_acc;
    logic [WIN_IW-1:0]    w_hd, w_head_n;
    logic                 w_full;
    logic [FILL_W-1:0]    w_fill_n, w_hd_inc;
    logic signed [63:0]   w_lsum_n, w_asum_n;
    logic signed [DW-1:0] w_ds_n, w_dc_n;

    aso_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mul_go),
        .i_a(r_ma), .i_b(r_mb), .o_prod(w_prod), .o_stat(w_mst)
    );

    aso_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_hi(r_dhi), .i_lo(r_dlo), .i_d(r_dd), .o_quot(w_quot), .o_stat(w_dst)
    );

    aso_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_cor_go),
        .i_phase(r_ph), .o_sin(w_sin), .o_cos(w_cos), .o_stat(w_cst)
    );

    assign s_tready    = r_state == S_IDLE;
    assign w_in_acc    = s_tvalid && s_tready;
    assign o_cfg_ready = 1'b1;

    assign w_in_steer = $signed(s_tdata[95:64]);
    assign w_steer_cl = (w_in_steer > STEER_MAX)  ? STEER_MAX :
                        (w_in_steer < -STEER_MAX) ? -STEER_MAX : w_in_steer;
    assign w_steer64  = 64'(r_steer);
    assign w_sin64    = 64'(w_sin);
    assign w_cos64    = 64'(w_cos);
    assign w_ccl      = (w_cos64 < 64'sd1) ? 64'sd1 : w_cos64;
    assign w_s0x4     = 64'(r_s0) <<< 2;
    assign w_ds_n     = (DW'(w_sin) - DW'(r_s0)) <<< 2;
    assign w_dc_n     = (DW'(w_cos) - DW'(r_c0)) <<< 2;
    assign w_ds       = 64'(w_ds_n);
    assign w_dc64     = 64'(r_dc);
    assign w_post32   = f_mul_post(w_prod, 32, r_sgn);
    assign w_dist     = f_mul_post(w_prod, 16, r_wa[63]);
    assign w_lin      = f_sat_sub(w_dist, r_prev);
    assign w_t1       = w_post32;
    assign w_m        = f_mag(w_t1);
    assign w_h        = (f_mag(r_ang) < ANG_EPS) ? f_sat_add(r_hd, r_ang >>> 1) : r_hd;
    assign w_hnew     = f_sat_add(r_hd, r_ang);
    assign w_php      = r_hneg ? (32'd0 - w_prod[95:64]) : w_prod[95:64];
    assign w_vdt      = $signed({1'b0, r_t}) - $signed({1'b0, r_tref});
    assign w_vm       = w_vdt[48] ? 48'(-w_vdt) : w_vdt[47:0];
    assign w_tdiff    = r_t - r_tref;

    assign w_hd      = (FILL_W'(r_head) >= FILL_W'(WINDOW)) ? '0 : r_head;
    assign w_full    = r_fill >= FILL_W'(WINDOW);
    assign w_fill_n  = w_full ? FILL_W'(WINDOW) : (r_fill + FILL_W'(1));
    assign w_hd_inc  = FILL_W'(w_hd) + FILL_W'(1);
    assign w_head_n  = (w_hd_inc >= FILL_W'(WINDOW)) ? '0 : WIN_IW'(w_hd_inc);
    assign w_lsum_n  = (w_full ? (r_lsum - r_lwin[w_hd]) : r_lsum) + r_ls;
    assign w_asum_n  = (w_full ? (r_asum - r_awin[w_hd]) : r_asum) + r_as;

    always_ff @(posedge i_clk) begin
        if (r_state == P_WIN) begin
            r_lwin[w_hd] <= r_ls;
            r_awin[w_hd] <= r_as;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            r_cor_go <= 1'b0;
            r_mv     <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_hd     <= '0;
            r_prev   <= '0;
            r_tref   <= '0;
            r_lsum   <= '0;
            r_asum   <= '0;
            r_lspd   <= '0;
            r_aspd   <= '0;
            r_head   <= '0;
            r_fill   <= '0;
            r_sep    <= SEP_RESET;
            r_rad    <= RAD_RESET;
        end else begin
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            r_cor_go <= 1'b0;
            if (m_tvalid && m_tready && r_state != S_OUT) begin
                r_mv <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_WHEEL_SEP: r_sep <= i_cfg_data;
                    REG_WHEEL_RAD: r_rad <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_op    <= s_tuser;
                        r_wa    <= $signed(s_tdata[63:0]);
                        r_steer <= w_steer_cl;
                        r_lv    <= $signed(s_tdata[159:96]);
                        r_av    <= $signed(s_tdata[223:160]);
                        r_t     <= s_tdata[271:224];
                        r_flag  <= 1'b0;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    unique case (r_op)
                        OP_ENC: begin
                            r_mul_go <= 1'b1;
                            r_ma     <= f_mag(w_steer64);
                            r_mb     <= TWO_OVER_PI_Q32;
                            r_sgn    <= r_steer[31];
                            r_state  <= E_STEER;
                        end
                        OP_VEL: begin
                            r_vneg   <= w_vdt[48];
                            r_vm     <= w_vm;
                            r_lspd   <= r_lv;
                            r_aspd   <= r_av;
                            r_tref   <= r_t;
                            r_mul_go <= 1'b1;
                            r_ma     <= f_mag(r_lv);
                            r_mb     <= {16'd0, w_vm};
                            r_state  <= V_LM;
                        end
                        OP_TREF: begin
                            r_tref  <= r_t;
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                E_STEER: begin
                    if (w_mst.done) begin
                        r_ph     <= w_post32[31:0];
                        r_cor_go <= 1'b1;
                        r_state  <= E_TRIG;
                    end
                end
                E_TRIG: begin
                    if (w_cst.done) begin
                        r_div_go <= 1'b1;
                        r_dhi    <= f_mag(w_sin64) >> 32;
                        r_dlo    <= f_mag(w_sin64) << 32;
                        r_dd     <= 64'(w_ccl);
                        r_sgn    <= w_sin64[63];
                        r_state  <= E_TAN;
                    end
                end
                E_TAN: begin
                    if (w_dst.done) begin
                        r_tn     <= f_apply(w_quot, r_sgn);
                        r_mul_go <= 1'b1;
                        r_ma     <= f_mag(r_wa);
                        r_mb     <= {32'd0, r_rad};
                        r_state  <= E_DIST;
                    end
                end
                E_DIST: begin
                    if (w_mst.done) begin
                        r_prev   <= w_dist;
                        r_lin    <= w_lin;
                        r_mul_go <= 1'b1;
                        r_ma     <= f_mag(r_tn);
                        r_mb     <= f_mag(w_lin);
                        r_sgn    <= r_tn[63] ^ w_lin[63];
                        r_state  <= E_ANGM;
                    end
                end
                E_ANGM: begin
                    if (w_mst.done) begin
                        r_div_go <= 1'b1;
                        r_dhi    <= w_m >> 48;
                        r_dlo    <= w_m << 16;
                        r_dd     <= (r_sep == 32'd0) ? 64'd1 : {32'd0, r_sep};
                        r_sgn    <= w_t1[63];
                        r_state  <= E_ANGD;
                    end
                end
                E_ANGD: begin
                    if (w_dst.done) begin
                        r_ang   <= f_apply(w_quot, r_sgn);
                        r_state <= I_BEG;
                    end
                end
                V_LM: begin
                    if (w_mst.done) begin
                        r_div_go <= 1'b1;
                        r_dhi    <= w_prod[127:64];
                        r_dlo    <= w_prod[63:0];
                        r_dd     <= US_PER_S;
                        r_sgn    <= r_lspd[63] ^ r_vneg;
                        r_state  <= V_LD;
                    end
                end
                V_LD: begin
                    if (w_dst.done) begin
                        r_lin    <= f_apply(w_quot, r_sgn);
                        r_mul_go <= 1'b1;
                        r_ma     <= f_mag(r_aspd);
                        r_mb     <= {16'd0, r_vm};
                        r_state  <= V_AM;
                    end
                end
                V_AM: begin
                    if (w_mst.done) begin
                        r_div_go <= 1'b1;
                        r_dhi    <= w_prod[127:64];
                        r_dlo    <= w_prod[63:0];
                        r_dd     <= US_PER_S;
                        r_sgn    <= r_aspd[63] ^ r_vneg;
                        r_state  <= V_AD;
                    end
                end
                V_AD: begin
                    if (w_dst.done) begin
                        r_ang   <= f_apply(w_quot, r_sgn);
                        r_state <= I_BEG;
                    end
                end
                I_BEG: begin
                    r_small  <= f_mag(r_ang) < ANG_EPS;
                    r_hneg   <= w_h[63];
                    r_mul_go <= 1'b1;
                    r_ma     <= f_mag(w_h);
                    r_mb     <= INV_2PI_Q64;
                    r_state  <= I_PH0;
                end
                I_PH0: begin
                    if (w_mst.done) begin
                        r_ph     <= w_php;
                        r_cor_go <= 1'b1;
                        r_state  <= I_CS0;
                    end
                end
                I_CS0: begin
                    if (w_cst.done) begin
                        r_s0 <= w_sin;
                        r_c0 <= w_cos;
                        if (r_small) begin
                            r_mul_go <= 1'b1;
                            r_ma     <= f_mag(r_lin);
                            r_mb     <= f_mag(w_cos64 <<< 2);
                            r_sgn    <= r_lin[63] ^ w_cos64[63];
                            r_state  <= IS_X;
                        end else begin
                            r_div_go <= 1'b1;
                            r_dhi    <= f_mag(r_lin) >> 32;
                            r_dlo    <= f_mag(r_lin) << 32;
                            r_dd     <= f_mag(r_ang);
                            r_sgn    <= r_lin[63] ^ r_ang[63];
                            r_state  <= IL_R;
                        end
                    end
                end
                IS_X: begin
                    if (w_mst.done) begin
                        r_x      <= f_sat_add(r_x, w_post32);
                        r_mul_go <= 1'b1;
                        r_ma     <= f_mag(r_lin);
                        r_mb     <= f_mag(w_s0x4);
                        r_sgn    <= r_lin[63] ^ w_s0x4[63];
                        r_state  <= IS_Y;
                    end
                end
                IS_Y: begin
                    if (w_mst.done) begin
                        r_y     <= f_sat_add(r_y, w_post32);
                        r_hd    <= w_hnew;
                        r_state <= P_CHK;
                    end
                end
                IL_R: begin
                    if (w_dst.done) begin
                        r_r      <= f_apply(w_quot, r_sgn);
                        r_hd     <= w_hnew;
                        r_hneg   <= w_hnew[63];
                        r_mul_go <= 1'b1;
                        r_ma     <= f_mag(w_hnew);
                        r_mb     <= INV_2PI_Q64;
                        r_state  <= IL_PH1;
                    end
                end
                IL_PH1: begin
                    if (w_mst.done) begin
                        r_ph     <= w_php;
                        r_cor_go <= 1'b1;
                        r_state  <= IL_CS1;
                    end
                end
                IL_CS1: begin
                    if (w_cst.done) begin
                        r_dc     <= w_dc_n;
                        r_mul_go <= 1'b1;
                        r_ma     <= f_mag(r_r);
                        r_mb     <= f_mag(w_ds);
                        r_sgn    <= r_r[63] ^ w_ds[63];
                        r_state  <= IL_X;
                    end
                end
                IL_X: begin
                    if (w_mst.done) begin
                        r_x      <= f_sat_add(r_x, w_post32);
                        r_mul_go <= 1'b1;
                        r_ma     <= f_mag(r_r);
                        r_mb     <= f_mag(w_dc64);
                        r_sgn    <= r_r[63] ^ w_dc64[63];
                        r_state  <= IL_Y;
                    end
                end
                IL_Y: begin
                    if (w_mst.done) begin
                        r_y     <= f_sat_sub(r_y, w_post32);
                        r_state <= P_CHK;
                    end
                end
                P_CHK: begin
                    if (r_op == OP_ENC) begin
                        if (r_t >= r_tref && w_tdiff >= MIN_DT_US) begin
                            r_dt     <= w_tdiff;
                            r_tref   <= r_t;
                            r_mul_go <= 1'b1;
                            r_ma     <= f_mag(r_lin);
                            r_mb     <= US_PER_S;
                            r_state  <= P_LM;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_flag  <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                P_LM: begin
                    if (w_mst.done) begin
                        r_div_go <= 1'b1;
                        r_dhi    <= w_prod[127:64];
                        r_dlo    <= w_prod[63:0];
                        r_dd     <= {16'd0, r_dt};
                        r_sgn    <= r_lin[63];
                        r_state  <= P_LD;
                    end
                end
                P_LD: begin
                    if (w_dst.done) begin
                        r_ls     <= f_clamp(f_apply(w_quot, r_sgn));
                        r_mul_go <= 1'b1;
                        r_ma     <= f_mag(r_ang);
                        r_mb     <= US_PER_S;
                        r_state  <= P_AM;
                    end
                end
                P_AM: begin
                    if (w_mst.done) begin
                        r_div_go <= 1'b1;
                        r_dhi    <= w_prod[127:64];
                        r_dlo    <= w_prod[63:0];
                        r_dd     <= {16'd0, r_dt};
                        r_sgn    <= r_ang[63];
                        r_state  <= P_AD;
                    end
                end
                P_AD: begin
                    if (w_dst.done) begin
                        r_as    <= f_clamp(f_apply(w_quot, r_sgn));
                        r_state <= P_WIN;
                    end
                end
                P_WIN: begin
                    r_lsum   <= w_lsum_n;
                    r_asum   <= w_asum_n;
                    r_fill   <= w_fill_n;
                    r_head   <= w_head_n;
                    r_div_go <= 1'b1;
                    r_dhi    <= 64'd0;
                    r_dlo    <= f_mag(w_lsum_n);
                    r_dd     <= 64'(w_fill_n);
                    r_sgn    <= w_lsum_n[63];
                    r_state  <= P_LMEAN;
                end
                P_LMEAN: begin
                    if (w_dst.done) begin
                        r_lspd   <= f_apply(w_quot, r_sgn);
                        r_div_go <= 1'b1;
                        r_dhi    <= 64'd0;
                        r_dlo    <= f_mag(r_asum);
                        r_dd     <= 64'(r_fill);
                        r_sgn    <= r_asum[63];
                        r_state  <= P_AMEAN;
                    end
                end
                P_AMEAN: begin
                    if (w_dst.done) begin
                        r_aspd  <= f_apply(w_quot, r_sgn);
                        r_flag  <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_mv || m_tready) begin
                        r_mv    <= 1'b1;
                        r_mdata <= {r_aspd, r_lspd, r_hd, r_y, r_x};
                        r_muser <= r_flag;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_mv;
    assign m_tdata  = r_mdata;
    assign m_tuser  = r_muser;

    `ASO_ASSERT_IMPL(a_idle_units, i_clk, i_rst_n, s_tready,
        !(w_mst.busy || w_dst.busy || w_cst.busy), "unit busy while core idle")
    `ASO_ASSERT_IMPL(a_mul_free, i_clk, i_rst_n, r_mul_go || r_div_go,
        !w_mst.busy && !w_dst.busy, "unit launched while busy")
    `ASO_ASSERT(a_fill_range, i_clk, i_rst_n,
        (r_fill <= FILL_W'(WINDOW)) && (FILL_W'(r_head) < FILL_W'(WINDOW)),
        "window fill or head out of range")
    `ASO_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_tvalid && s_tready, !s_tready,
        "second item taken while one is in flight")

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the articulated steering odometry core.
`timescale 1ns / 1ps

module tb_top;
    import aso_pkg::*;

    typedef logic signed [63:0] s64_t;

    typedef struct {
        logic [1:0]  op;
        s64_t        wheel;
        logic [31:0] steer;
        s64_t        lin;
        s64_t        ang;
        logic [47:0] t_us;
    } odo_item_t;

    typedef struct packed {
        s64_t pos_x;
        s64_t pos_y;
        s64_t heading;
        s64_t lin_spd;
        s64_t ang_spd;
        logic updated;
    } pose_t;

    localparam logic [1:0] OP_NONE = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [271:0]         s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [319:0]         m_tdata;
    logic                 m_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IW-1:0]    i_cfg_index;
    logic [31:0]          i_cfg_data;

    articulated_steering_odometry_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    logic [31:0] sep_q, rad_q;
    s64_t        x_q, y_q, hdg_q, prev_dist_q, lin_sum_q, ang_sum_q, lin_spd_q, ang_spd_q;
    logic [47:0] tref_q;
    s64_t        lin_win[WINDOW];
    s64_t        ang_win[WINDOW];
    logic [3:0]  win_head, win_fill;

    odo_item_t   pending_items[$];
    pose_t       expected_poses[$];
    odo_item_t   cur_item;
    int          send_idle, recv_idle;
    int          mismatches;
    bit          failed;

    s64_t atan_lut[30] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
        64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };

    function automatic logic [63:0] abs64(input s64_t v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic s64_t signed_sat(input logic [63:0] m, input logic neg);
        if (neg) return m[63] ? S64_MIN : -$signed(m);
        return m[63] ? S64_MAX : $signed(m);
    endfunction

    function automatic s64_t add_sat(input s64_t a, input s64_t b);
        s64_t s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) return S64_MAX;
        if (a[63] && b[63] && !s[63]) return S64_MIN;
        return s;
    endfunction

    function automatic s64_t sub_sat(input s64_t a, input s64_t b);
        s64_t s;
        s = a - b;
        if (!a[63] && b[63] && s[63]) return S64_MAX;
        if (a[63] && !b[63] && !s[63]) return S64_MIN;
        return s;
    endfunction

    function automatic logic [63:0] div_wide(input logic [63:0] hi, input logic [63:0] lo,
                                             input logic [63:0] d);
        logic [127:0] q;
        if (hi >= d) return '1;
        q = {hi, lo} / {64'd0, d};
        return q[63:0];
    endfunction

    function automatic s64_t fx_mul(input s64_t a, input s64_t b, input int sh);
        logic [127:0] p;
        logic [63:0]  r;
        p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
        r = ((p[127:64] >> sh) != 64'd0) ? '1 : 64'(p >> sh);
        return signed_sat(r, a[63] != b[63]);
    endfunction

    function automatic s64_t fx_div(input s64_t a, input s64_t b, input int sh);
        logic [63:0] m, d;
        m = abs64(a);
        d = abs64(b);
        if (d == 0) d = 1;
        return signed_sat(div_wide(m >> (64 - sh), m << sh, d), a[63] != b[63]);
    endfunction

    function automatic s64_t muldiv(input s64_t a, input logic [63:0] m,
                                    input logic [63:0] d, input logic flip);
        logic [127:0] p;
        p = {64'd0, abs64(a)} * {64'd0, m};
        return signed_sat(div_wide(p[127:64], p[63:0], d), a[63] != flip);
    endfunction

    function automatic s64_t f_clamp_tb(input s64_t v);
        if (v > SAMPLE_MAX) return SAMPLE_MAX;
        if (v < -SAMPLE_MAX) return -SAMPLE_MAX;
        return v;
    endfunction

    task automatic rotate(input logic [31:0] ph, output s64_t s, output s64_t c);
        logic [31:0] q, rr;
        s64_t z, x, y, dx, dy;
        q = ((ph + 32'h20000000) >> 30) & 32'd3;
        rr = ph - (q << 30);
        z = s64_t'($signed(rr));
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - atan_lut[i];
            end else begin
                x = x + dx; y = y - dy; z = z + atan_lut[i];
            end
        end
        case (q[1:0])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic logic [31:0] hdg_phase(input s64_t h);
        logic [127:0] p;
        p = {64'd0, abs64(h)} * {64'd0, INV_2PI_Q64};
        return h[63] ? 32'(-p[95:64]) : p[95:64];
    endfunction

    task automatic advance_pose(input s64_t lin, input s64_t ang);
        s64_t s0, c0, s1, c1, r;
        if (abs64(ang) < ANG_EPS) begin
            rotate(hdg_phase(add_sat(hdg_q, ang >>> 1)), s0, c0);
            x_q = add_sat(x_q, fx_mul(lin, c0 * 4, 32));
            y_q = add_sat(y_q, fx_mul(lin, s0 * 4, 32));
            hdg_q = add_sat(hdg_q, ang);
        end else begin
            rotate(hdg_phase(hdg_q), s0, c0);
            r = fx_div(lin, ang, 32);
            hdg_q = add_sat(hdg_q, ang);
            rotate(hdg_phase(hdg_q), s1, c1);
            x_q = add_sat(x_q, fx_mul(r, (s1 - s0) * 4, 32));
            y_q = sub_sat(y_q, fx_mul(r, (c1 - c0) * 4, 32));
        end
    endtask

    task automatic predict_pose(input odo_item_t it, output pose_t res);
        s64_t st, s, c, tn, wheel_dist, lin, ang, ls, as_;
        s64_t dts;
        logic [63:0] dt;
        logic upd;
        upd = 1'b0;
        if (it.op == OP_ENC) begin
            st = s64_t'($signed(it.steer));
            if (st > STEER_MAX) st = STEER_MAX;
            if (st < -STEER_MAX) st = -STEER_MAX;
            rotate(32'(fx_mul(st, $signed(TWO_OVER_PI_Q32), 32)), s, c);
            if (c < 1) c = 1;
            tn = fx_div(s, c, 32);
            wheel_dist = fx_mul(it.wheel, $signed({32'd0, rad_q}), 16);
            lin = sub_sat(wheel_dist, prev_dist_q);
            prev_dist_q = wheel_dist;
            ang = fx_div(fx_mul(tn, lin, 32), $signed({32'd0, sep_q}), 16);
            advance_pose(lin, ang);
            if (it.t_us >= tref_q && it.t_us - tref_q >= MIN_DT_US) begin
                dt = {16'd0, it.t_us - tref_q};
                tref_q = it.t_us;
                ls = f_clamp_tb(muldiv(lin, US_PER_S, dt, 1'b0));
                as_ = f_clamp_tb(muldiv(ang, US_PER_S, dt, 1'b0));
                if (win_head >= WINDOW) win_head = 0;
                if (win_fill >= WINDOW) begin
                    win_fill = WINDOW;
                    lin_sum_q = lin_sum_q - lin_win[win_head];
                    ang_sum_q = ang_sum_q - ang_win[win_head];
                end else begin
                    win_fill = win_fill + 1;
                end
                lin_win[win_head] = ls;
                ang_win[win_head] = as_;
                lin_sum_q = lin_sum_q + ls;
                ang_sum_q = ang_sum_q + as_;
                win_head = (win_head + 1 >= WINDOW) ? 4'd0 : win_head + 4'd1;
                lin_spd_q = lin_sum_q / $signed({60'd0, win_fill});
                ang_spd_q = ang_sum_q / $signed({60'd0, win_fill});
                upd = 1'b1;
            end
        end else if (it.op == OP_VEL) begin
            dts = $signed({16'd0, it.t_us}) - $signed({16'd0, tref_q});
            lin_spd_q = it.lin;
            ang_spd_q = it.ang;
            tref_q = it.t_us;
            advance_pose(muldiv(it.lin, abs64(dts), US_PER_S, dts[63]),
                         muldiv(it.ang, abs64(dts), US_PER_S, dts[63]));
            upd = 1'b1;
        end else if (it.op == OP_TREF) begin
            tref_q = it.t_us;
        end
        res.pos_x = x_q;
        res.pos_y = y_q;
        res.heading = hdg_q;
        res.lin_spd = lin_spd_q;
        res.ang_spd = ang_spd_q;
        res.updated = upd;
    endtask

    // driver
    always @(posedge i_clk) begin
        pose_t res;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                predict_pose(cur_item, res);
                expected_poses.push_back(res);
            end
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
                cur_item = pending_items.pop_front();
                s_tdata <= {cur_item.t_us, cur_item.ang, cur_item.lin,
                            cur_item.steer, cur_item.wheel};
                s_tuser <= cur_item.op;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        pose_t exp_p;
        pose_t got;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.pos_x = m_tdata[63:0];
                got.pos_y = m_tdata[127:64];
                got.heading = m_tdata[191:128];
                got.lin_spd = m_tdata[255:192];
                got.ang_spd = m_tdata[319:256];
                got.updated = m_tuser;
                if (expected_poses.size() == 0) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction at %0t", $realtime);
                end else begin
                    exp_p = expected_poses.pop_front();
                    if (got != exp_p) begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp x=%h y=%h h=%h ls=%h as=%h u=%b",
                                     exp_p.pos_x, exp_p.pos_y, exp_p.heading,
                                     exp_p.lin_spd, exp_p.ang_spd, exp_p.updated);
                            $display("          got x=%h y=%h h=%h ls=%h as=%h u=%b",
                                     got.pos_x, got.pos_y, got.heading,
                                     got.lin_spd, got.ang_spd, got.updated);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_WHEEL_SEP) sep_q = val;
        else rad_q = val;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_tvalid || expected_poses.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic s64_t rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic s64_t rand_small(input int bits);
        s64_t v;
        v = rand64() >>> (64 - bits);
        return v;
    endfunction

    task automatic push_item(input logic [1:0] op, input s64_t wheel, input logic [31:0] steer,
                             input s64_t lin, input s64_t ang, input logic [47:0] t_us);
        odo_item_t it;
        it.op = op; it.wheel = wheel; it.steer = steer;
        it.lin = lin; it.ang = ang; it.t_us = t_us;
        pending_items.push_back(it);
    endtask

    s64_t        gen_wheel;
    logic [47:0] gen_time;

    task automatic push_random(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 60) begin
                gen_wheel = gen_wheel + rand_small($urandom_range(20, 36));
                gen_time = gen_time + 48'($urandom_range(20, 4000));
                push_item(OP_ENC, gen_wheel,
                          ($urandom_range(9) == 0) ? 32'($urandom_range(0, 2000))
                                                   : 32'($signed(rand_small(32)) % 1686629714),
                          rand64(), rand64(), gen_time);
            end else if (k < 75) begin
                gen_time = gen_time + 48'($urandom_range(0, 30000));
                push_item(OP_VEL, rand64(), $urandom, rand_small($urandom_range(8, 40)),
                          rand_small($urandom_range(8, 36)), gen_time);
            end else if (k < 80) begin
                gen_time = gen_time + 48'($urandom_range(0, 500));
                push_item(OP_TREF, rand64(), $urandom, rand64(), rand64(), gen_time);
            end else begin
                push_item(2'($urandom_range(3)), rand64(), $urandom, rand64(), rand64(),
                          {$urandom, 16'($urandom)});
            end
        end
    endtask

    logic [31:0] sep_set[6] = '{32'd65536, 32'd1, 32'hFFFFFFFF, 32'd0, 32'd98304, 32'd52428};
    logic [31:0] rad_set[6] = '{32'd6554, 32'hFFFFFFFF, 32'd0, 32'd65536, 32'd3277, 32'd13107};

    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        failed = 1'b0;
        mismatches = 0;
        send_idle = 16;
        recv_idle = 80;
        sep_q = SEP_RESET; rad_q = RAD_RESET;
        x_q = 0; y_q = 0; hdg_q = 0; prev_dist_q = 0; tref_q = 0;
        lin_sum_q = 0; ang_sum_q = 0; lin_spd_q = 0; ang_spd_q = 0;
        win_head = 0; win_fill = 0;
        for (int i = 0; i < WINDOW; i++) begin
            lin_win[i] = 0;
            ang_win[i] = 0;
        end
        gen_wheel = 0;
        gen_time = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            write_reg(REG_WHEEL_SEP, sep_set[ph]);
            write_reg(REG_WHEEL_RAD, (ph == 5) ? $urandom : rad_set[ph]);
            send_idle = (ph < 2) ? 16 : (ph < 4) ? 80 : 0;
            recv_idle = (ph < 2) ? 80 : (ph < 4) ? 16 : 0;
            if (ph == 0) begin
                push_item(OP_TREF, 0, 0, 0, 0, 48'd0);
                push_item(OP_ENC, 0, 0, 0, 0, 48'd50);
                push_item(OP_ENC, 64'sh1_0000_0000, STEER_MAX, 0, 0, 48'd200);
                push_item(OP_ENC, 64'sh2_0000_0000, -STEER_MAX, 0, 0, 48'd400);
                push_item(OP_ENC, 64'sh3_0000_0000, 32'h7FFFFFFF, 0, 0, 48'd600);
                push_item(OP_ENC, 64'sh4_0000_0000, 32'h80000000, 0, 0, 48'd800);
                push_item(OP_ENC, 64'sh4_1000_0000, 32'd3, 0, 0, 48'd900);
                push_item(OP_ENC, S64_MAX, 32'd100000, 0, 0, 48'd1100);
                push_item(OP_ENC, S64_MIN, -32'sd100000, 0, 0, 48'd1300);
                push_item(OP_ENC, 0, 32'd5000, 0, 0, 48'd1000);
                push_item(OP_VEL, 0, 0, 64'sh1_0000_0000, 64'sh0_4000_0000, 48'd3000);
                push_item(OP_VEL, 0, 0, 64'sh2_0000_0000, -64'sh0_1000_0000, 48'd2000);
                push_item(OP_VEL, 0, 0, S64_MAX, S64_MIN, 48'd500000);
                push_item(OP_VEL, 0, 0, 0, 0, 48'd500000);
                push_item(OP_NONE, -1, '1, -1, -1, '1);
                push_item(OP_TREF, 0, 0, 0, 0, '1);
                push_item(OP_ENC, 64'sh5_0000_0000, 32'd1000000, 0, 0, '1);
                push_item(OP_TREF, 0, 0, 0, 0, 48'd0);
                gen_time = 48'd0;
                gen_wheel = 0;
            end
            push_random(180);
        end

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (expected_poses.size() > 0) failed = 1'b1;
        if (!failed) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("status: fail");
        $finish;
    end

endmodule
